// File: src/top_k_score_heap_assert.svh
// Assertion macros for the score heap block.
// Used by modules that carry clk_i and rst_ni.
`ifndef TOP_K_SCORE_HEAP_ASSERT_SVH
`define TOP_K_SCORE_HEAP_ASSERT_SVH

`define TKSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TKSH_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/tksh_pkg.sv
// Types and codes for the score heap block.
// No dependencies.
package tksh_pkg;

  typedef struct packed {
    logic               mode;
    logic [31:0]        player_id;
    logic [63:0]        name_tag;
    logic signed [31:0] points;
  } tksh_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         rank;
    logic [31:0]        entry_id;
    logic [63:0]        entry_tag;
    logic signed [31:0] entry_points;
    logic signed [31:0] lowest_points;
    logic [6:0]         count;
    logic               last;
  } tksh_res_t;

  typedef struct packed {
    logic [31:0]        id;
    logic [63:0]        tag;
    logic signed [31:0] points;
  } tksh_entry_t;

  localparam logic       MODE_SUBMIT = 1'b0;
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_RANKED   = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

endpackage

// File: src/tksh_ram.sv
// Entry memory, one write port and one registered read port.
// Depends on tksh_pkg.
module tksh_ram import tksh_pkg::*; #(
  parameter int DEPTH = 10,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  tksh_entry_t   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output tksh_entry_t   rdata_o
);

  tksh_entry_t mem [DEPTH];
  tksh_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/top_k_score_heap.sv
// Keeps the CAPACITY highest scores as a binary min-heap in a block memory.
// A submit scans the stored entries one by one for a matching id or tag,
// then, unless it is rejected, sifts the entry up or down the heap level
// by level, then reports. A read copies the heap into a scratch memory
// entry by entry and runs a selection sort there, emitting one result at
// the end of each pass; a read of an empty heap reports ST_EMPTY with no
// copy. Each memory has a single read port. Results appear for one cycle on strobe_o and cannot be held.
// Depends on tksh_pkg, tksh_ram and top_k_score_heap_assert.svh.
`include "top_k_score_heap_assert.svh"

module top_k_score_heap import tksh_pkg::*; #(
  parameter int CAPACITY = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  tksh_req_t req_i,
  output logic      strobe_o,
  output tksh_res_t res_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SCMP, S_UPR, S_UPC, S_DNL, S_DNR, S_DNC, S_FIN,
    S_CPR, S_CPW, S_PRI, S_PCI, S_PRJ, S_PCJ, S_PEND
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q, k_q, i_q, j_q;
  logic [AW-1:0]      pos_q, mx_q;
  logic               rv_q;
  logic [2:0]         stat_q;
  tksh_entry_t        cur_q, lch_q, ei_q, best_q;
  logic signed [31:0] root_q;
  logic               strobe_q;
  tksh_res_t          res_q;

  logic          m_we, s_we;
  logic [AW-1:0] m_waddr, m_raddr, s_waddr, s_raddr;
  tksh_entry_t   m_wdata, s_wdata, m_rdata, s_rdata;

  logic [AW-1:0] par;
  logic [XW-1:0] lc, rc, cnt_x;
  logic          up_swap, hit, dn_move;
  tksh_entry_t   dn_best;
  logic [AW-1:0] dn_idx;
  logic signed [31:0] lowest;

  assign par   = AW'((pos_q - AW'(1)) >> 1);
  assign lc    = {1'b0, pos_q, 1'b1};
  assign rc    = lc + XW'(1);
  assign cnt_x = XW'(count_q);
  assign up_swap = cur_q.points < m_rdata.points;
  assign hit   = (m_rdata.id == cur_q.id) || (m_rdata.tag == cur_q.tag);
  assign lowest = (count_q != '0) ? root_q : 32'sd0;

  always_comb begin
    dn_best = cur_q;
    dn_idx  = pos_q;
    if (lch_q.points < dn_best.points) begin
      dn_best = lch_q;
      dn_idx  = lc[AW-1:0];
    end
    if (rv_q && (m_rdata.points < dn_best.points)) begin
      dn_best = m_rdata;
      dn_idx  = rc[AW-1:0];
    end
    dn_move = dn_idx != pos_q;
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = pos_q;
    m_wdata = cur_q;
    m_raddr = k_q[AW-1:0];
    s_we    = 1'b0;
    s_waddr = k_q[AW-1:0];
    s_wdata = m_rdata;
    s_raddr = i_q[AW-1:0];
    unique case (state_q)
      S_UPR: begin
        m_raddr = par;
        m_we    = pos_q == '0;
      end
      S_UPC: begin
        m_we = 1'b1;
        if (up_swap) begin
          m_wdata = m_rdata;
        end
      end
      S_DNL: begin
        m_raddr = lc[AW-1:0];
        m_we    = lc >= cnt_x;
      end
      S_DNR: m_raddr = rc[AW-1:0];
      S_DNC: begin
        m_we    = 1'b1;
        m_wdata = dn_best;
      end
      S_CPW: s_we = 1'b1;
      S_PRJ: s_raddr = j_q[AW-1:0];
      S_PEND: begin
        s_we    = mx_q != i_q[AW-1:0];
        s_waddr = mx_q;
        s_wdata = ei_q;
      end
      default: ;
    endcase
  end

  tksh_ram #(.DEPTH(CAPACITY), .AW(AW)) u_heap (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  tksh_ram #(.DEPTH(CAPACITY), .AW(AW)) u_scratch (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
      root_q   <= '0;
    end else begin
      strobe_q <= 1'b0;
      if (m_we && (m_waddr == '0)) begin
        root_q <= m_wdata.points;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            cur_q <= '{id: req_i.player_id, tag: req_i.name_tag, points: req_i.points};
            k_q   <= '0;
            if (req_i.mode == MODE_SUBMIT) begin
              state_q <= S_SRCH;
            end else if (count_q == '0) begin
              strobe_q <= 1'b1;
              res_q    <= '{status: ST_EMPTY, rank: '0, entry_id: '0,
                            entry_tag: '0, entry_points: '0,
                            lowest_points: '0, count: '0, last: 1'b1};
            end else begin
              state_q <= S_CPR;
            end
          end
        end
        S_SRCH: begin
          if (k_q == count_q) begin
            if (count_q < CW'(CAPACITY)) begin
              pos_q   <= count_q[AW-1:0];
              count_q <= count_q + CW'(1);
              stat_q  <= ST_INSERTED;
              state_q <= S_UPR;
            end else if (root_q < cur_q.points) begin
              pos_q   <= '0;
              stat_q  <= ST_REPLACED;
              state_q <= S_DNL;
            end else begin
              stat_q  <= ST_REJECTED;
              state_q <= S_FIN;
            end
          end else begin
            state_q <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (hit) begin
            pos_q   <= k_q[AW-1:0];
            stat_q  <= ST_UPDATED;
            state_q <= (cur_q.points < m_rdata.points) ? S_UPR : S_DNL;
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_SRCH;
          end
        end
        S_UPR: state_q <= (pos_q == '0) ? S_FIN : S_UPC;
        S_UPC: begin
          if (up_swap) begin
            pos_q   <= par;
            state_q <= S_UPR;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DNL: state_q <= (lc >= cnt_x) ? S_FIN : S_DNR;
        S_DNR: begin
          lch_q   <= m_rdata;
          rv_q    <= rc < cnt_x;
          state_q <= S_DNC;
        end
        S_DNC: begin
          if (dn_move) begin
            pos_q   <= dn_idx;
            state_q <= S_DNL;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          strobe_q <= 1'b1;
          res_q    <= '{status: stat_q, rank: '0, entry_id: cur_q.id,
                        entry_tag: cur_q.tag, entry_points: cur_q.points,
                        lowest_points: lowest, count: 7'(count_q), last: 1'b1};
          state_q  <= S_IDLE;
        end
        S_CPR: state_q <= S_CPW;
        S_CPW: begin
          k_q <= k_q + CW'(1);
          if (k_q + CW'(1) == count_q) begin
            i_q     <= '0;
            state_q <= S_PRI;
          end else begin
            state_q <= S_CPR;
          end
        end
        S_PRI: state_q <= S_PCI;
        S_PCI: begin
          ei_q    <= s_rdata;
          best_q  <= s_rdata;
          mx_q    <= i_q[AW-1:0];
          j_q     <= i_q + CW'(1);
          state_q <= S_PRJ;
        end
        S_PRJ: state_q <= (j_q == count_q) ? S_PEND : S_PCJ;
        S_PCJ: begin
          if (best_q.points < s_rdata.points) begin
            best_q <= s_rdata;
            mx_q   <= j_q[AW-1:0];
          end
          j_q     <= j_q + CW'(1);
          state_q <= S_PRJ;
        end
        S_PEND: begin
          strobe_q <= 1'b1;
          res_q    <= '{status: ST_RANKED, rank: 6'(i_q), entry_id: best_q.id,
                        entry_tag: best_q.tag, entry_points: best_q.points,
                        lowest_points: lowest, count: 7'(count_q),
                        last: (i_q + CW'(1)) == count_q};
          i_q      <= i_q + CW'(1);
          state_q  <= ((i_q + CW'(1)) == count_q) ? S_IDLE : S_PRI;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy     = state_q != S_IDLE;
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  `TKSH_ASSERT(a_count_cap, count_q <= CW'(CAPACITY), "entry count above capacity")
  `TKSH_ASSERT_IMPL(a_start_busy, start && !busy && (req_i.mode == MODE_SUBMIT), busy, "submit not taken")
  `TKSH_ASSERT_IMPL(a_idle_nowrite, !busy, !m_we || busy, "heap written while idle")
  `TKSH_ASSERT(a_strobe_last, strobe_o && res_o.last |-> !busy, "last result while busy")

endmodule
